/* sv/sac_pkg.sv */
// sac_pkg: shared constants and types for the stack arithmetic coprocessor
// no dependencies
`default_nettype none
package sac_pkg;
    localparam int STACK_BYTES = 16;
    localparam int PTR_W = $clog2(STACK_BYTES);

    localparam logic [1:0] ACC_WR_DATA = 2'd0;
    localparam logic [1:0] ACC_WR_CMD  = 2'd1;
    localparam logic [1:0] ACC_RD_DATA = 2'd2;
    localparam logic [1:0] ACC_RD_STAT = 2'd3;

    localparam logic [4:0] OPC_NOP  = 5'h00;
    localparam logic [4:0] OPC_ADD  = 5'h0c;
    localparam logic [4:0] OPC_SUB  = 5'h0d;
    localparam logic [4:0] OPC_MULL = 5'h0e;
    localparam logic [4:0] OPC_DIV  = 5'h0f;
    localparam logic [4:0] OPC_CHS  = 5'h14;
    localparam logic [4:0] OPC_MULH = 5'h16;
    localparam logic [4:0] OPC_PTO  = 5'h17;
    localparam logic [4:0] OPC_POP  = 5'h18;
    localparam logic [4:0] OPC_XCH  = 5'h19;
    localparam logic [1:0] MODE_INT32 = 2'b01;

    localparam logic [3:0] ERR_NONE  = 4'd0;
    localparam logic [3:0] ERR_DIV0  = 4'd1;
    localparam logic [3:0] ERR_OVF   = 4'd2;
    localparam logic [3:0] ERR_UNSUP = 4'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RDPOP, ST_LOAD, ST_LOADW, ST_EXEC, ST_MUL, ST_DIV,
        ST_STORE, ST_STAT
    } state_t;

    typedef struct packed {
        logic       start;
        logic       is_div;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] prod;
        logic [31:0] quot;
    } alu_rsp_t;
endpackage
`default_nettype wire

/* sv/sac_muldiv.sv */
// sac_muldiv: iterative unsigned multiplier and divider, one bit per cycle
// depends on sac_pkg
`default_nettype none
module sac_muldiv
    import sac_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire alu_req_t req,
    output alu_rsp_t      rsp
);
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        div_reg, div_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] rem_reg, rem_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] psum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        acc_reg <= acc_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        div_next  = div_reg;
        acc_next  = acc_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        trial = {rem_reg, acc_reg[31]} - {1'b0, b_reg};
        psum  = {1'b0, acc_reg[63:32]} + (acc_reg[0] ? {1'b0, b_reg} : 33'd0);
        if (req.start)
        begin
            run_next = 1'b1;
            div_next = req.is_div;
            cnt_next = 6'd32;
            acc_next = {32'd0, req.a};
            b_next   = req.b;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            if (div_reg)
            begin
                // restoring division, quotient bits shift into acc low
                if (!trial[32])
                begin
                    rem_next = trial[31:0];
                    acc_next = {32'd0, acc_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[30:0], acc_reg[31]};
                    acc_next = {32'd0, acc_reg[30:0], 1'b0};
                end
            end
            else
            begin
                acc_next = {psum, acc_reg[31:1]};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;
    assign rsp.quot = acc_reg[31:0];
endmodule
`default_nettype wire

/* sv/stack_arith_coprocessor_int32.sv */
// stack arithmetic coprocessor, 32-bit signed integer subset
// a data read strobes its word from ST_RDPOP through the strobe register, a status read from ST_STAT
// busy is low only in the idle state; a data write is taken there, while data reads, status reads and commands
// keep busy high until their work is done, as set by the byte-wide stack memory port
// and the one-bit-per-cycle mul/div unit; the receiver cannot stall
// reset clears pointer, flags and, by a sweep of the stack memory, all stack bytes
`default_nettype none
module stack_arith_coprocessor_int32
    import sac_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] op,
    input  wire logic [7:0] data,
    output logic            strobe,
    output logic [7:0]      read_data
);
    logic [7:0] mem [STACK_BYTES];
    logic [7:0] rd_q;

    state_t          state_reg, state_next;
    logic [PTR_W-1:0] top_reg, top_next;
    logic [3:0]      err_reg, err_next;
    logic            carry_reg, carry_next;
    logic            clr_reg, clr_next;
    logic [PTR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [1:0]      acc_reg, acc_next;
    logic [7:0]      cmd_reg, cmd_next;
    logic [3:0]      idx_reg, idx_next;
    logic [63:0]     opnd_reg, opnd_next;
    logic [63:0]     res_reg, res_next;
    logic [3:0]      wcnt_reg, wcnt_next;
    logic            neg_reg, neg_next;
    logic            strobe_reg, strobe_next;
    logic [7:0]      out_reg, out_next;

    logic            we;
    logic [PTR_W-1:0] waddr, raddr;
    logic [7:0]      wdata;
    alu_req_t        req;
    alu_rsp_t        rsp;

    logic [31:0] t_w, s_w, ms, mt, sum, dif;
    logic [32:0] add33;
    logic [63:0] prod_s;
    logic [4:0]  opc;

    sac_muldiv u_md (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_q <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            top_reg     <= '0;
            err_reg     <= ERR_NONE;
            carry_reg   <= 1'b0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            err_reg     <= err_next;
            carry_reg   <= carry_next;
            clr_reg     <= clr_next;
            clr_cnt_reg <= clr_cnt_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        opnd_reg <= opnd_next;
        res_reg  <= res_next;
        wcnt_reg <= wcnt_next;
        neg_reg  <= neg_next;
        out_reg  <= out_next;
    end

    // opnd holds NOS in [63:32], TOS in [31:0]
    assign t_w    = opnd_reg[31:0];
    assign s_w    = opnd_reg[63:32];
    assign ms     = s_w[31] ? (32'd0 - s_w) : s_w;
    assign mt     = t_w[31] ? (32'd0 - t_w) : t_w;
    assign add33  = {1'b0, s_w} + {1'b0, t_w};
    assign sum    = add33[31:0];
    assign dif    = s_w - t_w;
    assign opc    = cmd_reg[4:0];
    assign prod_s = neg_reg ? (64'd0 - rsp.prod) : rsp.prod;

    always_comb
    begin
        state_next   = state_reg;
        top_next     = top_reg;
        err_next     = err_reg;
        carry_next   = carry_reg;
        clr_next     = clr_reg;
        clr_cnt_next = clr_cnt_reg;
        acc_next     = acc_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        opnd_next    = opnd_reg;
        res_next     = res_reg;
        wcnt_next    = wcnt_reg;
        neg_next     = neg_reg;
        out_next     = out_reg;
        strobe_next  = 1'b0;
        we           = 1'b0;
        waddr        = top_reg;
        wdata        = data;
        raddr        = top_reg - PTR_W'(idx_reg);
        req.start    = 1'b0;
        req.is_div   = 1'b0;
        req.a        = ms;
        req.b        = mt;
        busy         = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (clr_reg)
                begin
                    we    = 1'b1;
                    waddr = clr_cnt_reg;
                    wdata = 8'd0;
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == PTR_W'(STACK_BYTES - 1))
                    begin
                        clr_next = 1'b0;
                    end
                end
                else
                begin
                    busy = 1'b0;
                    if (start)
                    begin
                        acc_next = op;
                        cmd_next = data;
                        unique case (op)
                            ACC_WR_DATA:
                            begin
                                we       = 1'b1;
                                waddr    = top_reg + 1'b1;
                                top_next = top_reg + 1'b1;
                            end
                            ACC_RD_DATA:
                            begin
                                raddr      = top_reg;
                                state_next = ST_RDPOP;
                            end
                            default:
                            begin
                                idx_next   = 4'd0;
                                wcnt_next  = 4'd0;
                                state_next = ST_LOAD;
                            end
                        endcase
                    end
                end
            end
            ST_RDPOP:
            begin
                out_next    = rd_q;
                strobe_next = 1'b1;
                top_next    = top_reg - 1'b1;
                state_next  = ST_IDLE;
            end
            ST_LOAD:
            begin
                // issue reads of 8 bytes, top first; data arrives in the next cycle via rd_q
                idx_next   = idx_reg + 4'd1;
                state_next = ST_LOADW;
            end
            ST_LOADW:
            begin
                // byte k below top: k<4 is TOS byte (3-k), else NOS byte (7-k)
                opnd_next[8*(7-int'(wcnt_reg[2:0] ^ 3'd4)) +: 8] = rd_q;
                wcnt_next = wcnt_reg + 4'd1;
                if (wcnt_reg == 4'd7)
                begin
                    state_next = (acc_reg == ACC_RD_STAT) ? ST_STAT : ST_EXEC;
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            ST_STAT:
            begin
                out_next    = {1'b0, t_w[31], (t_w == 32'd0), err_reg, carry_reg};
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_EXEC:
            begin
                err_next   = ERR_NONE;
                carry_next = 1'b0;
                state_next = ST_IDLE;
                wcnt_next  = 4'd0;
                // res: word to write, top_next placement; wcnt counts bytes in store
                if (opc == OPC_NOP)
                begin
                    state_next = ST_IDLE;
                end
                else if (cmd_reg[6:5] != MODE_INT32)
                begin
                    err_next = ERR_UNSUP;
                end
                else
                begin
                    case (opc) inside
                        OPC_ADD:
                        begin
                            carry_next = add33[32];
                            res_next   = {32'd0, sum};
                            top_next   = top_reg - PTR_W'(4);
                            idx_next   = 4'd4;
                            state_next = ST_STORE;
                        end
                        OPC_SUB:
                        begin
                            carry_next = (s_w < t_w);
                            res_next   = {32'd0, dif};
                            top_next   = top_reg - PTR_W'(4);
                            idx_next   = 4'd4;
                            state_next = ST_STORE;
                        end
                        OPC_MULL, OPC_MULH:
                        begin
                            req.start  = 1'b1;
                            neg_next   = s_w[31] ^ t_w[31];
                            state_next = ST_MUL;
                        end
                        OPC_DIV:
                        begin
                            if (t_w == 32'd0)
                            begin
                                err_next = ERR_DIV0;
                            end
                            else if (s_w == 32'h8000_0000 && t_w == 32'hffff_ffff)
                            begin
                                err_next   = ERR_OVF;
                                res_next   = {32'd0, 32'h8000_0000};
                                top_next   = top_reg - PTR_W'(4);
                                idx_next   = 4'd4;
                                state_next = ST_STORE;
                            end
                            else
                            begin
                                req.start  = 1'b1;
                                req.is_div = 1'b1;
                                neg_next   = s_w[31] ^ t_w[31];
                                state_next = ST_DIV;
                            end
                        end
                        OPC_CHS:
                        begin
                            res_next   = {32'd0, 32'd0 - t_w};
                            idx_next   = 4'd4;
                            state_next = ST_STORE;
                        end
                        OPC_PTO:
                        begin
                            res_next   = {32'd0, t_w};
                            top_next   = top_reg + PTR_W'(4);
                            idx_next   = 4'd4;
                            state_next = ST_STORE;
                        end
                        OPC_POP:
                        begin
                            top_next = top_reg - PTR_W'(4);
                        end
                        OPC_XCH:
                        begin
                            res_next   = {t_w, s_w};
                            idx_next   = 4'd8;
                            state_next = ST_STORE;
                        end
                        default:
                        begin
                            err_next = ERR_UNSUP;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                if (rsp.done)
                begin
                    res_next   = {32'd0, (opc == OPC_MULH) ? prod_s[63:32] : prod_s[31:0]};
                    top_next   = top_reg - PTR_W'(4);
                    idx_next   = 4'd4;
                    state_next = ST_STORE;
                end
            end
            ST_DIV:
            begin
                if (rsp.done)
                begin
                    res_next   = {32'd0, neg_reg ? (32'd0 - rsp.quot) : rsp.quot};
                    top_next   = top_reg - PTR_W'(4);
                    idx_next   = 4'd4;
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                // byte k below top gets bits of res; low word first k=0..3
                we    = 1'b1;
                waddr = top_reg - PTR_W'(wcnt_reg);
                wdata = res_reg[8*(int'(wcnt_reg[2:0] ^ 3'd3)) +: 8];
                wcnt_next = wcnt_reg + 4'd1;
                if (wcnt_reg + 4'd1 == idx_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign strobe    = strobe_reg;
    assign read_data = out_reg;
endmodule
`default_nettype wire

/* tb/tb.sv */
// tb: self-checking bench for the stack arithmetic coprocessor, 32-bit integer subset
// keeps its own copy of the byte stack and flags, and checks every popped byte and status byte
// depends on sac_pkg and stack_arith_coprocessor_int32
`timescale 1ns / 100ps
`default_nettype none
module tb
    import sac_pkg::*;
();

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] op;
    logic [7:0] data;
    logic       strobe;
    logic [7:0] read_data;

    logic [7:0]       stk_mem [STACK_BYTES];
    logic [PTR_W-1:0] sp;
    logic [3:0]  err_code;
    logic        carry;
    logic [7:0]  pending_reads [$];
    int          errors;
    int          idle_pct;
    longint      cycles;

    stack_arith_coprocessor_int32 u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .data      (data),
        .strobe    (strobe),
        .read_data (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] word_at(input int depth);
        logic [31:0] w;
        w = '0;
        for (int i = 0; i < 4; i++)
            w = {w[23:0], stk_mem[PTR_W'(sp - PTR_W'(depth * 4 + i))]};
        return w;
    endfunction

    function automatic void put_word(input int depth, input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            stk_mem[PTR_W'(sp - PTR_W'(depth * 4 + i))] = w[31 - 8 * i -: 8];
    endfunction

    function automatic void replace_pair(input logic [31:0] r);
        sp = sp - PTR_W'(4);
        put_word(0, r);
    endfunction

    function automatic void run_command(input logic [7:0] cmd);
        logic [4:0]  opc;
        logic [31:0] t;
        logic [31:0] s;
        logic [63:0] p;
        logic [32:0] sum;
        logic [31:0] ms;
        logic [31:0] mt;
        logic [31:0] q;
        opc = cmd[4:0];
        t = word_at(0);
        s = word_at(1);
        p = $signed({{32{s[31]}}, s}) * $signed({{32{t[31]}}, t});
        err_code = ERR_NONE;
        carry = 1'b0;
        if (opc == OPC_NOP)
            return;
        if (cmd[6:5] != MODE_INT32)
        begin
            err_code = ERR_UNSUP;
            return;
        end
        case (opc)
            OPC_ADD:
            begin
                sum = {1'b0, s} + {1'b0, t};
                carry = sum[32];
                replace_pair(sum[31:0]);
            end
            OPC_SUB:
            begin
                carry = s < t;
                replace_pair(s - t);
            end
            OPC_MULL: replace_pair(p[31:0]);
            OPC_MULH: replace_pair(p[63:32]);
            OPC_DIV:
            begin
                if (t == 0)
                    err_code = ERR_DIV0;
                else if (s == 32'h8000_0000 && t == 32'hffff_ffff)
                begin
                    err_code = ERR_OVF;
                    replace_pair(32'h8000_0000);
                end
                else
                begin
                    ms = s[31] ? -s : s;
                    mt = t[31] ? -t : t;
                    q = ms / mt;
                    replace_pair((s[31] ^ t[31]) ? -q : q);
                end
            end
            OPC_CHS: put_word(0, -t);
            OPC_PTO:
            begin
                sp = sp + PTR_W'(4);
                put_word(0, t);
            end
            OPC_POP: sp = sp - PTR_W'(4);
            OPC_XCH:
            begin
                put_word(0, s);
                put_word(1, t);
            end
            default: err_code = ERR_UNSUP;
        endcase
    endfunction

    function automatic void predict_access(input logic [1:0] a, input logic [7:0] d);
        logic [31:0] t;
        case (a)
            ACC_WR_DATA:
            begin
                sp = sp + 1'b1;
                stk_mem[sp] = d;
            end
            ACC_WR_CMD: run_command(d);
            ACC_RD_DATA:
            begin
                pending_reads.push_back(stk_mem[sp]);
                sp = sp - 1'b1;
            end
            default:
            begin
                t = word_at(0);
                pending_reads.push_back({1'b0, t[31], t == 0, err_code, carry});
            end
        endcase
    endfunction

    task automatic send_access(input logic [1:0] a, input logic [7:0] d);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        op    <= a;
        data  <= d;
        do
            @(posedge clk);
        while (busy);
        predict_access(a, d);
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            send_access(ACC_WR_DATA, w[8 * i +: 8]);
    endtask

    task automatic read_word();
        for (int i = 0; i < 4; i++)
            send_access(ACC_RD_DATA, 8'h00);
    endtask

    task automatic binary_op(input logic [31:0] s, input logic [31:0] t, input logic [4:0] opc);
        push_word(s);
        push_word(t);
        send_access(ACC_WR_CMD, {1'b0, MODE_INT32, opc});
        send_access(ACC_RD_STAT, 8'h00);
        read_word();
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic test_directed();
        binary_op(32'h7fff_ffff, 32'h0000_0001, OPC_ADD);
        binary_op(32'hffff_ffff, 32'hffff_ffff, OPC_ADD);
        binary_op(32'h0000_0000, 32'h0000_0001, OPC_SUB);
        binary_op(32'h8000_0000, 32'h7fff_ffff, OPC_MULL);
        binary_op(32'h8000_0000, 32'h8000_0000, OPC_MULH);
        binary_op(32'h8000_0000, 32'hffff_ffff, OPC_DIV);
        binary_op(32'h1234_5678, 32'h0000_0000, OPC_DIV);
        binary_op(32'hffff_fff9, 32'h0000_0002, OPC_DIV);
        binary_op(32'h0000_0005, 32'h8000_0000, OPC_CHS);
        binary_op(32'h0000_0003, 32'h0000_0009, OPC_XCH);
        binary_op(32'h0000_0003, 32'h0000_0009, OPC_PTO);
        binary_op(32'h0000_0003, 32'h0000_0009, OPC_POP);
        binary_op(32'h0000_0003, 32'h0000_0000, OPC_NOP);
        binary_op(32'h0000_0003, 32'h0000_0009, 5'h1f);
        send_access(ACC_WR_CMD, {1'b1, 2'b10, OPC_ADD});
        send_access(ACC_RD_STAT, 8'hff);
        send_access(ACC_WR_CMD, 8'h80);
        send_access(ACC_RD_STAT, 8'h00);
        drain();
    endtask

    task automatic test_random(input int pct, input int n);
        logic [4:0] ops [10];
        logic [31:0] v;
        ops = '{OPC_NOP, OPC_ADD, OPC_SUB, OPC_MULL, OPC_DIV, OPC_CHS,
                OPC_MULH, OPC_PTO, OPC_POP, OPC_XCH};
        idle_pct = pct;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0: send_access(2'($urandom), 8'($urandom));
                1: send_access(ACC_WR_CMD, 8'($urandom));
                default:
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        v = $urandom;
                        case ($urandom_range(4))
                            0: v = 32'($signed(8'($urandom)));
                            1: v = {v[31], 31'($urandom_range(3))};
                            default: ;
                        endcase
                        push_word(v);
                    end
                    send_access(ACC_WR_CMD, {1'b0, MODE_INT32, ops[$urandom_range(9)]});
                    send_access(ACC_RD_STAT, 8'($urandom));
                    read_word();
                end
            endcase
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (strobe)
        begin
            if (pending_reads.size() == 0)
            begin
                $display("%0t: unexpected read word: expected none, actual %02h", $time,
                         read_data);
                errors++;
            end
            else if (pending_reads[0] !== read_data)
            begin
                $display("%0t: read word mismatch: expected %02h, actual %02h", $time,
                         pending_reads[0], read_data);
                errors++;
                void'(pending_reads.pop_front());
            end
            else
                void'(pending_reads.pop_front());
        end
        if (cycles > 3_000_000)
        begin
            $display("stack_arith_coprocessor_int32 verification failed");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_pct = 0;
        cycles = 0;
        sp = '0;
        err_code = ERR_NONE;
        carry = 1'b0;
        foreach (stk_mem[i])
            stk_mem[i] = 8'h00;
        rst_n = 1'b0;
        start = 1'b0;
        op = ACC_WR_DATA;
        data = 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (30) @(posedge clk);
        test_directed();
        test_random(0, 26);
        test_random(67, 26);
        test_random(38, 26);
        test_random(0, 26);
        if (errors == 0 && pending_reads.size() == 0)
            $display("stack_arith_coprocessor_int32 verification clean");
        else
            $display("stack_arith_coprocessor_int32 verification failed");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
sv/sac_pkg.sv
sv/sac_muldiv.sv
sv/stack_arith_coprocessor_int32.sv
tb/tb.sv
